/* rtl/etmt_pkg.sv */
// Shared constants for the event type map table: operation and status codes
// and fixed payload widths. No dependencies.
`default_nettype none

package etmt_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

/* rtl/event_type_map_table.sv */
// Event type map table: key-to-value map with a direct-mapped fast path and a
// linear scan over all entries. Depends on etmt_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | sink      | i_in_valid / o_in_ready   | i_func i_remote_type i_server_type
//   out     | source    | o_out_valid / i_out_ready | o_found o_mapped_type o_status
//
// Clear, key zero and unused operations go from idle straight to the result state.
// Home slot decision: the home slot is read in idle and decided in HCHK. Scan: from
// entry zero up, one entry per cycle through the single read port of the entry memory and one key compare.
// Reset clears the valid bits and sets the fast path; no clearing pass.
// A new transaction is taken only in idle; a held result stalls the sequencer
// in its result state but the output register frees the input side.
`default_nettype none

module event_type_map_table #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned KEY_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [etmt_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [etmt_pkg::TYPE_W-1:0]   i_remote_type,
    input  wire logic [etmt_pkg::TYPE_W-1:0]   i_server_type,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_found,
    output logic [etmt_pkg::TYPE_W-1:0]        o_mapped_type,
    output logic [etmt_pkg::STATUS_W-1:0]      o_status
);

    localparam int unsigned TW       = etmt_pkg::TYPE_W;
    localparam int unsigned KW       = (KEY_BITS < TW) ? KEY_BITS : TW;
    localparam int unsigned IDX_W    = $clog2(ENTRIES);
    localparam int unsigned KEY_SPAN = 1 << KW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HCHK = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [IDX_W-1:0] home_tab [KEY_SPAN];

    for (genvar k = 0; k < KEY_SPAN; k++) begin : g_home
        assign home_tab[k] = IDX_W'(k % ENTRIES);
    end

    logic [KW+TW-1:0]              r_mem [ENTRIES];
    logic [ENTRIES-1:0]            r_vld, n_vld;
    logic [1:0]                    r_state, n_state;
    logic [etmt_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [KW-1:0]                 r_key, n_key;
    logic [TW-1:0]                 r_val, n_val;
    logic                          r_fast, n_fast;
    logic [IDX_W-1:0]              r_rd_idx;
    logic [KW+TW-1:0]              r_rd_word;
    logic                          r_rd_vld;
    logic                          r_res_found, n_res_found;
    logic [TW-1:0]                 r_res_mapped, n_res_mapped;
    logic [etmt_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_found;
    logic [TW-1:0]                 r_out_mapped;
    logic [etmt_pkg::STATUS_W-1:0] r_out_status;

    logic [KW-1:0]    in_key;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [KW-1:0]    rd_key;
    logic [TW-1:0]    rd_val;
    logic             key_eq;
    logic             accept;
    logic             out_free;
    logic             load_out;

    assign in_key   = i_remote_type[KW-1:0];
    assign rd_key   = r_rd_word[KW+TW-1:TW];
    assign rd_val   = r_rd_word[TW-1:0];
    assign key_eq   = r_rd_vld && (rd_key == r_key);
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign load_out = (r_state == S_RES) && out_free;

    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_key        = r_key;
        n_val        = r_val;
        n_fast       = r_fast;
        n_vld        = r_vld;
        n_res_found  = r_res_found;
        n_res_mapped = r_res_mapped;
        n_res_status = r_res_status;
        rd_addr      = r_rd_idx;
        wr_en        = 1'b0;
        case (r_state)
            S_IDLE: begin
                rd_addr = home_tab[in_key];
                if (accept) begin
                    n_func       = i_func;
                    n_key        = in_key;
                    n_val        = i_server_type;
                    n_res_found  = 1'b0;
                    n_res_mapped = '0;
                    n_res_status = etmt_pkg::ST_DONE;
                    n_state      = S_RES;
                    if ((i_func == etmt_pkg::FUNC_INSERT || i_func == etmt_pkg::FUNC_LOOKUP)
                        && in_key != '0) begin
                        n_state = S_HCHK;
                    end
                    if (i_func == etmt_pkg::FUNC_CLEAR) begin
                        n_vld  = '0;
                        n_fast = 1'b1;
                    end
                end
            end
            S_HCHK: begin
                rd_addr = '0;
                if (r_func == etmt_pkg::FUNC_INSERT) begin
                    if (key_eq && rd_val == r_val) begin
                        n_res_status = etmt_pkg::ST_ALREADY;
                        n_state      = S_RES;
                    end else if (!r_rd_vld) begin
                        wr_en           = 1'b1;
                        n_vld[r_rd_idx] = 1'b1;
                        n_state         = S_RES;
                    end else begin
                        n_fast  = 1'b0;
                        n_state = S_SCAN;
                    end
                end else begin
                    if (r_fast && key_eq) begin
                        n_res_found  = 1'b1;
                        n_res_mapped = rd_val;
                        n_state      = S_RES;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_addr = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                if (r_func == etmt_pkg::FUNC_INSERT && !r_rd_vld) begin
                    wr_en           = 1'b1;
                    n_vld[r_rd_idx] = 1'b1;
                    n_state         = S_RES;
                end else if (r_func != etmt_pkg::FUNC_INSERT && key_eq) begin
                    n_res_found  = 1'b1;
                    n_res_mapped = rd_val;
                    n_state      = S_RES;
                end else if (r_rd_idx == LAST_IDX) begin
                    if (r_func == etmt_pkg::FUNC_INSERT) begin
                        n_res_status = etmt_pkg::ST_FULL;
                    end
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_fast      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_fast      <= n_fast;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_key        <= n_key;
        r_val        <= n_val;
        r_res_found  <= n_res_found;
        r_res_mapped <= n_res_mapped;
        r_res_status <= n_res_status;
        r_rd_idx     <= rd_addr;
        r_rd_vld     <= r_vld[rd_addr];
        if (load_out) begin
            r_out_found  <= r_res_found;
            r_out_mapped <= r_res_mapped;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_rd_idx] <= {r_key, r_val};
        end
        r_rd_word <= r_mem[rd_addr];
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_mapped_type = r_out_mapped;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

/* rtl/etmt_checker.sv */
// Port-level checks for event_type_map_table, bound to the top level.
// Depends on etmt_pkg.
`default_nettype none

module etmt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_found,
    input wire logic [etmt_pkg::TYPE_W-1:0]   o_mapped_type,
    input wire logic [etmt_pkg::STATUS_W-1:0] o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_mapped_type) && $stable(o_status))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after accepted transaction");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_mapped_type == '0)
        else $error("mapped type nonzero without a hit");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == etmt_pkg::ST_DONE)
        else $error("lookup hit with non-done status");

endmodule

bind event_type_map_table etmt_checker u_etmt_checker (.*);

`default_nettype wire
